[rtl/i2c_master_transfer_sequencer_defines.svh]
// Assertion macros shared by the I2C master transfer sequencer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CMS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2cms_pkg.sv]
// Types, codes and sizes for the I2C master transfer sequencer.
// No dependencies; used by every module of the block.
package i2cms_pkg;

    localparam int BUFFER_DEPTH   = 32;
    localparam int PTR_W          = $clog2(BUFFER_DEPTH);
    localparam int COUNT_W        = 6;
    localparam int OUT_FIFO_DEPTH = 3;
    localparam int OUT_FIFO_IDX_W = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_FIFO_CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    // item kinds
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;

    // bus status codes
    localparam logic [3:0] ST_START      = 4'd0;
    localparam logic [3:0] ST_REP_START  = 4'd1;
    localparam logic [3:0] ST_SLAW_ACK   = 4'd2;
    localparam logic [3:0] ST_DATAW_ACK  = 4'd3;
    localparam logic [3:0] ST_SLAW_NACK  = 4'd4;
    localparam logic [3:0] ST_DATAW_NACK = 4'd5;
    localparam logic [3:0] ST_SLAR_ACK   = 4'd6;
    localparam logic [3:0] ST_DATAR_ACK  = 4'd7;
    localparam logic [3:0] ST_DATAR_NACK = 4'd8;
    localparam logic [3:0] ST_SLAR_NACK  = 4'd9;
    localparam logic [3:0] ST_NONE       = 4'd10;

    // START / acknowledge control codes
    localparam logic [1:0] CTL_NONE  = 2'd0;
    localparam logic [1:0] CTL_SET   = 2'd1;
    localparam logic [1:0] CTL_CLEAR = 2'd2;

    // register indexes (by paddr[2])
    localparam logic REG_TRANSFER_LENGTH  = 1'b0;
    localparam logic REG_RESTART_AT_COUNT = 1'b1;

    typedef struct packed {
        logic               rd_sel;
        logic               tx_load;
        logic [1:0]         start_ctl;
        logic               stop_request;
        logic [1:0]         ack_ctl;
        logic               event_done;
        logic [COUNT_W-1:0] bytes_left;
    } step_ctl_t;

    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [PTR_W-1:0] rd_addr;
    } mem_req_t;

    // result record, last field in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] bytes_left;
        logic               event_done;
        logic [1:0]         ack_ctl;
        logic               stop_request;
        logic [1:0]         start_ctl;
        logic [7:0]         tx_byte;
        logic               tx_load;
        logic [7:0]         entry_read;
    } out_rec_t;

endpackage

[rtl/i2cms_step.sv]
// Next-state and control decode for one request of the transfer sequencer.
// Depends on i2cms_pkg.
module i2cms_step (
    input  logic [1:0]                    action,
    input  logic [4:0]                    entry_index,
    input  logic [7:0]                    entry_value,
    input  logic [3:0]                    status_code,
    input  logic [7:0]                    received_byte,
    input  logic [i2cms_pkg::PTR_W-1:0]   buffer_pointer,
    input  logic [i2cms_pkg::COUNT_W-1:0] remaining_count,
    input  logic [i2cms_pkg::COUNT_W-1:0] transfer_length,
    input  logic [i2cms_pkg::COUNT_W-1:0] restart_at_count,
    output logic [i2cms_pkg::PTR_W-1:0]   pointer_next,
    output logic [i2cms_pkg::COUNT_W-1:0] count_next,
    output i2cms_pkg::mem_req_t           mem_req,
    output i2cms_pkg::step_ctl_t          ctl
);

    function automatic logic [i2cms_pkg::PTR_W-1:0] ptr_up(
        input logic [i2cms_pkg::PTR_W-1:0] p
    );
        if (p == i2cms_pkg::PTR_W'(i2cms_pkg::BUFFER_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [i2cms_pkg::COUNT_W-1:0] count_dn(
        input logic [i2cms_pkg::COUNT_W-1:0] c
    );
        return (c == '0) ? c : c - 1'b1;
    endfunction

    logic [i2cms_pkg::PTR_W-1:0]   ptr_inc;
    logic [i2cms_pkg::COUNT_W-1:0] cnt_base;

    assign ptr_inc  = ptr_up(buffer_pointer);
    assign cnt_base = (status_code == i2cms_pkg::ST_START) ? transfer_length
                                                           : remaining_count;

    always_comb begin
        pointer_next     = buffer_pointer;
        count_next       = remaining_count;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = entry_index;
        mem_req.wr_data  = entry_value;
        mem_req.rd_addr  = entry_index;
        ctl.rd_sel       = 1'b0;
        ctl.tx_load      = 1'b0;
        ctl.start_ctl    = i2cms_pkg::CTL_NONE;
        ctl.stop_request = 1'b0;
        ctl.ack_ctl      = i2cms_pkg::CTL_NONE;
        ctl.event_done   = 1'b0;

        case (action)
            i2cms_pkg::ACT_LOAD: begin
                mem_req.wr_en = 1'b1;
            end
            i2cms_pkg::ACT_READ: begin
                ctl.rd_sel = 1'b1;
            end
            i2cms_pkg::ACT_STATUS: begin
                ctl.event_done  = 1'b1;
                mem_req.wr_addr = buffer_pointer;
                mem_req.wr_data = received_byte;
                mem_req.rd_addr = buffer_pointer;
                case (status_code)
                    i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START: begin
                        // rewind on a fresh START, then send the address byte
                        if (status_code == i2cms_pkg::ST_START) begin
                            pointer_next    = '0;
                            mem_req.rd_addr = '0;
                        end
                        count_next    = count_dn(cnt_base);
                        ctl.tx_load   = 1'b1;
                        ctl.start_ctl = i2cms_pkg::CTL_CLEAR;
                    end
                    i2cms_pkg::ST_SLAW_ACK, i2cms_pkg::ST_DATAW_ACK: begin
                        if (remaining_count != '0) begin
                            pointer_next = ptr_inc;
                            if (remaining_count != restart_at_count) begin
                                mem_req.rd_addr = ptr_inc;
                                ctl.tx_load     = 1'b1;
                                count_next      = count_dn(remaining_count);
                            end else begin
                                ctl.start_ctl = i2cms_pkg::CTL_SET;
                            end
                        end else begin
                            ctl.stop_request = 1'b1;
                        end
                    end
                    i2cms_pkg::ST_SLAW_NACK, i2cms_pkg::ST_DATAW_NACK,
                    i2cms_pkg::ST_SLAR_NACK: begin
                        ctl.stop_request = 1'b1;
                    end
                    i2cms_pkg::ST_SLAR_ACK: begin
                        pointer_next = ptr_inc;
                    end
                    i2cms_pkg::ST_DATAR_ACK: begin
                        ctl.ack_ctl   = (remaining_count > 6'd1) ? i2cms_pkg::CTL_SET
                                                                 : i2cms_pkg::CTL_CLEAR;
                        mem_req.wr_en = 1'b1;
                        pointer_next  = ptr_inc;
                        count_next    = count_dn(remaining_count);
                    end
                    i2cms_pkg::ST_DATAR_NACK: begin
                        mem_req.wr_en    = 1'b1;
                        pointer_next     = ptr_inc;
                        count_next       = count_dn(remaining_count);
                        ctl.stop_request = 1'b1;
                    end
                    i2cms_pkg::ST_NONE: begin
                    end
                    default: begin
                        ctl.stop_request = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase

        ctl.bytes_left = count_next;
    end

endmodule

[rtl/i2cms_out_fifo.sv]
// Three-entry result queue between the decode stage and the result channel.
// Depends on i2cms_pkg.
module i2cms_out_fifo (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  i2cms_pkg::out_rec_t                  push_rec,
    input  logic                                 pop,
    output logic                                 head_valid,
    output i2cms_pkg::out_rec_t                  head_rec,
    output logic [i2cms_pkg::OUT_FIFO_CNT_W-1:0] count
);

    i2cms_pkg::out_rec_t                   entry_reg [i2cms_pkg::OUT_FIFO_DEPTH];
    logic [i2cms_pkg::OUT_FIFO_IDX_W-1:0]  head_reg, head_next;
    logic [i2cms_pkg::OUT_FIFO_IDX_W-1:0]  tail_reg, tail_next;
    logic [i2cms_pkg::OUT_FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                                  do_pop;

    function automatic logic [i2cms_pkg::OUT_FIFO_IDX_W-1:0] idx_up(
        input logic [i2cms_pkg::OUT_FIFO_IDX_W-1:0] i
    );
        if (i == i2cms_pkg::OUT_FIFO_IDX_W'(i2cms_pkg::OUT_FIFO_DEPTH - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

    assign do_pop     = pop && (cnt_reg != '0);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = entry_reg[head_reg];
    assign count      = cnt_reg;

    always_comb begin
        head_next = do_pop ? idx_up(head_reg) : head_reg;
        tail_next = push ? idx_up(tail_reg) : tail_reg;
        cnt_next  = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= push_rec;
        end
    end

endmodule

[rtl/i2c_master_transfer_sequencer.sv]
// I2C master transfer sequencer: byte store, pointer/count state, result queue.
// Depends on i2cms_pkg, i2cms_step, i2cms_out_fifo and the assertion macro header.
//
// One request per clock enters on the s_ channel while s_tready is high; each
// request gives exactly one result on the m_ channel, in order. A request carries
// a kind in s_tuser: load a byte into the 32-entry store, read a byte back, or
// report an I2C bus status event. Status events walk the buffer pointer and
// remaining count and tell the bus driver what to do next: load a byte to send,
// set or clear START, request STOP, set or clear acknowledge. A START event
// rewinds the pointer and reloads the count from transfer_length; while sending,
// the byte slot where the count equals restart_at_count becomes a repeated
// START. An accepted request passes through the in-flight stage into the result
// queue, which raises m_tvalid, and the block sustains one request per cycle
// while s_tready is high: the pointer and count update at acceptance, so the
// next request sees them at once, and the store's single registered read port
// supplies data to the in-flight stage. A three-entry result queue absorbs the
// one request in flight plus output back-pressure, so s_tready depends only on
// registers and drops only once the queue and the in-flight slot hold three.
// Store entries come out of reset unknown; read only entries already loaded
// or received. Write the registers only while no request is in flight.
`include "i2c_master_transfer_sequencer_defines.svh"

module i2c_master_transfer_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] entry_index, [12:5] entry_value, [16:13] status_code,
    // [24:17] received_byte, [31:25] zero
    input  logic [31:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] entry_read, [8] tx_load, [16:9] tx_byte, [18:17] start_ctl,
    // [19] stop_request, [21:20] ack_ctl, [22] event_done, [28:23] bytes_left,
    // [31:29] zero
    output logic [31:0] m_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = i2cms_pkg::COUNT_W;

    // ------------------------------------------------------------------
    // Register port: two 6-bit registers, decoded on paddr[2].
    // ------------------------------------------------------------------
    logic [CW-1:0] transfer_length_reg;
    logic [CW-1:0] restart_at_count_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transfer_length_reg  <= '0;
            restart_at_count_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == i2cms_pkg::REG_TRANSFER_LENGTH) begin
                transfer_length_reg <= pwdata[CW-1:0];
            end else begin
                restart_at_count_reg <= pwdata[CW-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            i2cms_pkg::REG_TRANSFER_LENGTH:  prdata = {{(32-CW){1'b0}}, transfer_length_reg};
            i2cms_pkg::REG_RESTART_AT_COUNT: prdata = {{(32-CW){1'b0}}, restart_at_count_reg};
            default:                         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode and transfer state.
    // ------------------------------------------------------------------
    logic [i2cms_pkg::PTR_W-1:0] pointer_reg, pointer_next;
    logic [CW-1:0]               count_reg, count_next;
    i2cms_pkg::mem_req_t         mem_req;
    i2cms_pkg::step_ctl_t        step_ctl;
    logic                        s_accept;

    i2cms_step u_step (
        .action           (s_tuser),
        .entry_index      (s_tdata[4:0]),
        .entry_value      (s_tdata[12:5]),
        .status_code      (s_tdata[16:13]),
        .received_byte    (s_tdata[24:17]),
        .buffer_pointer   (pointer_reg),
        .remaining_count  (count_reg),
        .transfer_length  (transfer_length_reg),
        .restart_at_count (restart_at_count_reg),
        .pointer_next     (pointer_next),
        .count_next       (count_next),
        .mem_req          (mem_req),
        .ctl              (step_ctl)
    );

    assign s_accept = s_tvalid && s_tready;

    // advance pointer and count at acceptance so the next request sees them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pointer_reg <= '0;
            count_reg   <= '0;
        end else if (s_accept) begin
            pointer_reg <= pointer_next;
            count_reg   <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Byte store: at most one write and one registered read per request. A read
    // right after a write to the same entry sees the new byte, since the
    // write lands at the earlier edge.
    // ------------------------------------------------------------------
    logic [7:0] store_mem [i2cms_pkg::BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && mem_req.wr_en) begin
            store_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= store_mem[mem_req.rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // In-flight stage: holds decode results while the store read returns.
    // It never stalls; the queue always has room for it.
    // ------------------------------------------------------------------
    logic                 st1_valid_reg;
    i2cms_pkg::step_ctl_t st1_ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_ctl_reg <= step_ctl;
        end
    end

    // ------------------------------------------------------------------
    // Result assembly and queue.
    // ------------------------------------------------------------------
    i2cms_pkg::out_rec_t                  push_rec;
    i2cms_pkg::out_rec_t                  m_rec;
    logic [i2cms_pkg::OUT_FIFO_CNT_W-1:0] fifo_cnt;
    logic [i2cms_pkg::OUT_FIFO_CNT_W:0]   occupancy;

    always_comb begin
        push_rec.entry_read   = st1_ctl_reg.rd_sel ? rd_data_reg : 8'h00;
        push_rec.tx_load      = st1_ctl_reg.tx_load;
        push_rec.tx_byte      = st1_ctl_reg.tx_load ? rd_data_reg : 8'h00;
        push_rec.start_ctl    = st1_ctl_reg.start_ctl;
        push_rec.stop_request = st1_ctl_reg.stop_request;
        push_rec.ack_ctl      = st1_ctl_reg.ack_ctl;
        push_rec.event_done   = st1_ctl_reg.event_done;
        push_rec.bytes_left   = st1_ctl_reg.bytes_left;
    end

    i2cms_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (st1_valid_reg),
        .push_rec   (push_rec),
        .pop        (m_tready),
        .head_valid (m_tvalid),
        .head_rec   (m_rec),
        .count      (fifo_cnt)
    );

    assign m_tdata = {{(32 - $bits(i2cms_pkg::out_rec_t)){1'b0}}, m_rec};

    // take a request only if queue plus in-flight slot leaves room for it
    assign occupancy = {1'b0, fifo_cnt} + {{i2cms_pkg::OUT_FIFO_CNT_W{1'b0}}, st1_valid_reg};
    assign s_tready  = (occupancy < (i2cms_pkg::OUT_FIFO_CNT_W + 1)'(i2cms_pkg::OUT_FIFO_DEPTH));

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `I2CMS_ASSERT_SAME(a_queue_room, aclk, aresetn,
        st1_valid_reg,
        fifo_cnt != i2cms_pkg::OUT_FIFO_CNT_W'(i2cms_pkg::OUT_FIFO_DEPTH),
        "in-flight request found result queue full")
    `I2CMS_ASSERT_NEXT(a_accept_in_flight, aclk, aresetn,
        s_accept,
        st1_valid_reg,
        "accepted request did not reach the in-flight stage")
    `I2CMS_ASSERT_SAME(a_quiet_non_status, aclk, aresetn,
        m_tvalid && !m_rec.event_done,
        !m_rec.tx_load && !m_rec.stop_request &&
        (m_rec.start_ctl == i2cms_pkg::CTL_NONE) && (m_rec.ack_ctl == i2cms_pkg::CTL_NONE),
        "buffer request produced bus control")
    `I2CMS_ASSERT_SAME(a_tx_no_readback, aclk, aresetn,
        m_tvalid && m_rec.tx_load,
        m_rec.entry_read == 8'h00,
        "transmit result also carries a readback byte")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master transfer sequencer.
// Depends on i2cms_pkg and the i2c_master_transfer_sequencer RTL.
module tb;

    // Kinds and codes the package leaves unnamed
    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam logic [3:0] ST_OTHER    = 4'd11;
    localparam logic [3:0] ST_TOP      = 4'd15;

    // Register byte addresses, register i at 4*i
    localparam logic [2:0] ADDR_TRANSFER_LENGTH  = {i2cms_pkg::REG_TRANSFER_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_RESTART_AT_COUNT = {i2cms_pkg::REG_RESTART_AT_COUNT, 2'b00};

    localparam int TOTAL_ITEMS   = 1250;
    localparam int NUM_PHASES    = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;

    // Register settings per phase; a negative entry means pick at random
    localparam int PHASE_LEN [NUM_PHASES]     = '{0, 32, 63, 63, 8, 5, 1, -1};
    localparam int PHASE_RESTART [NUM_PHASES] = '{0, 31, 63, 0, 3, 5, 1, -1};

    // Predicts each step of the sequencer and holds the results still owed.
    class transfer_scoreboard;
        logic [7:0]                    store [i2cms_pkg::BUFFER_DEPTH];
        logic [i2cms_pkg::PTR_W-1:0]   ptr;
        logic [i2cms_pkg::COUNT_W-1:0] count;
        logic [i2cms_pkg::COUNT_W-1:0] xfer_len;
        logic [i2cms_pkg::COUNT_W-1:0] restart_at;
        i2cms_pkg::out_rec_t           pending_steps [$];
        int errors;
        int results;
        int status_events;
        int restarts;
        int stops;

        function new();
            ptr = '0;
            count = '0;
            xfer_len = '0;
            restart_at = '0;
            errors = 0;
            results = 0;
            status_events = 0;
            restarts = 0;
            stops = 0;
        endfunction

        function void set_register(input logic idx, input logic [31:0] value);
            if (idx == i2cms_pkg::REG_TRANSFER_LENGTH)
                xfer_len = value[i2cms_pkg::COUNT_W-1:0];
            else
                restart_at = value[i2cms_pkg::COUNT_W-1:0];
        endfunction

        function void count_down();
            if (count != '0)
                count = count - 1'b1;
        endfunction

        function void note_request(input logic [1:0] act, input logic [4:0] idx,
                                   input logic [7:0] val, input logic [3:0] code,
                                   input logic [7:0] rx);
            i2cms_pkg::out_rec_t step;
            step = '0;
            case (act)
                i2cms_pkg::ACT_LOAD: store[idx] = val;
                i2cms_pkg::ACT_READ: step.entry_read = store[idx];
                i2cms_pkg::ACT_STATUS: begin
                    step.event_done = 1'b1;
                    status_events++;
                    case (code)
                        i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START: begin
                            if (code == i2cms_pkg::ST_START) begin
                                ptr = '0;
                                count = xfer_len;
                            end
                            step.tx_load = 1'b1;
                            step.tx_byte = store[ptr];
                            count_down();
                            step.start_ctl = i2cms_pkg::CTL_CLEAR;
                        end
                        i2cms_pkg::ST_SLAW_ACK, i2cms_pkg::ST_DATAW_ACK: begin
                            if (count != '0) begin
                                ptr = ptr + 1'b1;
                                if (count != restart_at) begin
                                    step.tx_load = 1'b1;
                                    step.tx_byte = store[ptr];
                                    count_down();
                                end else begin
                                    step.start_ctl = i2cms_pkg::CTL_SET;
                                    restarts++;
                                end
                            end else begin
                                step.stop_request = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_SLAW_NACK, i2cms_pkg::ST_DATAW_NACK,
                        i2cms_pkg::ST_SLAR_NACK:
                            step.stop_request = 1'b1;
                        i2cms_pkg::ST_SLAR_ACK: ptr = ptr + 1'b1;
                        i2cms_pkg::ST_DATAR_ACK: begin
                            step.ack_ctl = (count > 1) ? i2cms_pkg::CTL_SET
                                                       : i2cms_pkg::CTL_CLEAR;
                            store[ptr] = rx;
                            ptr = ptr + 1'b1;
                            count_down();
                        end
                        i2cms_pkg::ST_DATAR_NACK: begin
                            store[ptr] = rx;
                            ptr = ptr + 1'b1;
                            count_down();
                            step.stop_request = 1'b1;
                        end
                        i2cms_pkg::ST_NONE: ;
                        default: step.stop_request = 1'b1;
                    endcase
                    if (step.stop_request)
                        stops++;
                end
                default: ;
            endcase
            step.bytes_left = count;
            pending_steps.push_back(step);
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [31:0] word);
            i2cms_pkg::out_rec_t got;
            i2cms_pkg::out_rec_t want;
            got = word[$bits(i2cms_pkg::out_rec_t)-1:0];
            results++;
            if (pending_steps.size() == 0) begin
                $error("result 0x%08h arrived with no request outstanding", word);
                errors++;
            end else begin
                want = pending_steps.pop_front();
                compare_field("entry_read", int'(want.entry_read), int'(got.entry_read));
                compare_field("tx_load", int'(want.tx_load), int'(got.tx_load));
                compare_field("tx_byte", int'(want.tx_byte), int'(got.tx_byte));
                compare_field("start_ctl", int'(want.start_ctl), int'(got.start_ctl));
                compare_field("stop_request", int'(want.stop_request),
                              int'(got.stop_request));
                compare_field("ack_ctl", int'(want.ack_ctl), int'(got.ack_ctl));
                compare_field("event_done", int'(want.event_done), int'(got.event_done));
                compare_field("bytes_left", int'(want.bytes_left), int'(got.bytes_left));
                compare_field("m_tdata padding", 0,
                              int'(word[31:$bits(i2cms_pkg::out_rec_t)]));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    transfer_scoreboard book = new();

    // Random bursts of idling on both channels while set
    bit idle_on = 1'b1;
    int counted_items = 0;
    int stall_cycles = 0;

    i2c_master_transfer_sequencer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check every result the moment it is handed over.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.check_result(m_tdata);
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: hold ready high for a while, then drop it for a burst.
    initial begin
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Offer one request, with an optional gap first, and wait for acceptance.
    task automatic send_request(input logic [1:0] act, input logic [4:0] idx,
                                input logic [7:0] val, input logic [3:0] code,
                                input logic [7:0] rx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, rx, code, val, idx};
        do @(posedge aclk); while (!s_tready);
        book.note_request(act, idx, val, code, rx);
        if (act != ACT_IGNORED)
            counted_items++;
    endtask

    // Random load or read of any entry; every entry is loaded before the first one.
    task automatic send_store_access();
        logic [1:0] act;
        act = $urandom_range(0, 1) ? i2cms_pkg::ACT_LOAD : i2cms_pkg::ACT_READ;
        send_request(act, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // Status event with junk in the unused fields, sometimes after a store access.
    task automatic send_status(input logic [3:0] code);
        if ($urandom_range(0, 9) == 0)
            send_store_access();
        send_request(i2cms_pkg::ACT_STATUS, 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)), code, 8'($urandom_range(0, 255)));
    endtask

    // Write one register over APB, read it back and compare.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        book.set_register(addr[2], value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(32-i2cms_pkg::COUNT_W){1'b0}}, value[i2cms_pkg::COUNT_W-1:0]}) begin
            $error("prdata mismatch at 0x%0h: expected %0d, got %0d",
                   addr, value[i2cms_pkg::COUNT_W-1:0], prdata);
            book.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Random upper bits in pwdata check that only the low six bits are kept.
    task automatic write_config(input int len, input int restart_cnt);
        logic [31:0] upper;
        upper = $urandom();
        write_register(ADDR_TRANSFER_LENGTH,
                       {upper[31:i2cms_pkg::COUNT_W], len[i2cms_pkg::COUNT_W-1:0]});
        upper = $urandom();
        write_register(ADDR_RESTART_AT_COUNT,
                       {upper[31:i2cms_pkg::COUNT_W], restart_cnt[i2cms_pkg::COUNT_W-1:0]});
    endtask

    // Drop valid, wait for every owed result, then let the pipeline go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.pending_steps.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_run_length();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    endfunction

    // One randomly shaped transfer: mostly well-formed, some noise and broken ones.
    task automatic run_transfer();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                // write: address, data bytes, sometimes a NACK at the end
                send_status(i2cms_pkg::ST_START);
                send_status(i2cms_pkg::ST_SLAW_ACK);
                n = pick_run_length();
                repeat (n) send_status(i2cms_pkg::ST_DATAW_ACK);
                if ($urandom_range(0, 2) == 0)
                    send_status(i2cms_pkg::ST_DATAW_NACK);
            end
            3, 4: begin
                // read: address, acked bytes, last byte NACKed
                send_status($urandom_range(0, 1) ? i2cms_pkg::ST_START
                                                 : i2cms_pkg::ST_REP_START);
                send_status(i2cms_pkg::ST_SLAR_ACK);
                n = pick_run_length();
                repeat (n) send_status(i2cms_pkg::ST_DATAR_ACK);
                send_status(i2cms_pkg::ST_DATAR_NACK);
            end
            5, 6: begin
                // combined: write part, repeated START, read part
                send_status(i2cms_pkg::ST_START);
                send_status(i2cms_pkg::ST_SLAW_ACK);
                n = pick_run_length();
                repeat (n) send_status(i2cms_pkg::ST_DATAW_ACK);
                send_status(i2cms_pkg::ST_REP_START);
                send_status(i2cms_pkg::ST_SLAR_ACK);
                n = pick_run_length();
                repeat (n) send_status(i2cms_pkg::ST_DATAR_ACK);
                send_status(i2cms_pkg::ST_DATAR_NACK);
            end
            7: begin
                repeat ($urandom_range(1, 4)) send_store_access();
            end
            8: begin
                // noise: any kind, any code
                repeat ($urandom_range(1, 4))
                    send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                                 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                 8'($urandom_range(0, 255)));
            end
            default: begin
                // broken transfer: START followed by arbitrary events
                send_status(i2cms_pkg::ST_START);
                repeat ($urandom_range(1, 6)) send_status(4'($urandom_range(0, 15)));
            end
        endcase
    endtask

    initial begin
        int target;
        int len;
        int restart_cnt;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= i2cms_pkg::ACT_LOAD;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short transfer of three with a repeated START when one byte is left.
        write_config(3, 1);

        // Load every store entry so no later access can hit an unwritten one;
        // the first and last entries get the byte extremes.
        for (int i = 0; i < i2cms_pkg::BUFFER_DEPTH; i++)
            send_request(i2cms_pkg::ACT_LOAD, 5'(i),
                         (i == 0) ? 8'h00 :
                         (i == i2cms_pkg::BUFFER_DEPTH-1) ? 8'hFF :
                         8'($urandom_range(0, 255)), 4'd0, 8'd0);

        // Directed walk through every status code and the corner cases.
        send_request(i2cms_pkg::ACT_READ, 5'd0, 8'hFF, ST_TOP, 8'hFF);
        send_request(i2cms_pkg::ACT_READ, 5'd31, 8'h00, 4'd0, 8'h00);
        // count loads as 3
        send_request(i2cms_pkg::ACT_STATUS, 5'd31, 8'hFF, i2cms_pkg::ST_START, 8'hFF);
        // next data byte
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_SLAW_ACK, 8'h00);
        // repeated START slot
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_DATAW_ACK, 8'h00);
        // count reaches zero
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_REP_START, 8'h00);
        // nothing left: STOP
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_DATAW_ACK, 8'h00);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_SLAW_NACK, 8'h00);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_DATAW_NACK, 8'h00);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_SLAR_NACK, 8'h00);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_SLAR_ACK, 8'h00);
        // count saturates at zero
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_DATAR_ACK, 8'hFF);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_START, 8'h00);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_SLAR_ACK, 8'h00);
        // more to come: set ack
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_DATAR_ACK, 8'h00);
        // last one: clear ack
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_DATAR_ACK, 8'h5A);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_DATAR_NACK, 8'hA5);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, i2cms_pkg::ST_NONE, 8'h00);
        send_request(i2cms_pkg::ACT_STATUS, 5'd0, 8'h00, ST_OTHER, 8'h00);
        send_request(i2cms_pkg::ACT_STATUS, 5'd31, 8'hFF, ST_TOP, 8'hFF);
        send_request(ACT_IGNORED, 5'd31, 8'hFF, ST_TOP, 8'hFF);      // unused kind
        send_request(i2cms_pkg::ACT_LOAD, 5'd31, 8'h00, 4'd0, 8'h00);
        send_request(i2cms_pkg::ACT_READ, 5'd31, 8'h00, 4'd0, 8'h00);
        // byte received above
        send_request(i2cms_pkg::ACT_READ, 5'd3, 8'h00, 4'd0, 8'h00);

        // Random phases, each under its own register setting. Drop idling in
        // the third phase and in the last one so back-to-back traffic is seen.
        target = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            idle_on = (p != 2) && (p != NUM_PHASES - 1);
            len = (PHASE_LEN[p] < 0) ? $urandom_range(0, 63) : PHASE_LEN[p];
            restart_cnt = (PHASE_RESTART[p] < 0) ? $urandom_range(0, 63) : PHASE_RESTART[p];
            write_config(len, restart_cnt);
            target += TOTAL_ITEMS / NUM_PHASES;
            while (counted_items < target)
                run_transfer();
        end
        settle();

        $display("Covered %0d requests, %0d results, %0d status events over %0d settings;",
                 counted_items, book.results, book.status_events, NUM_PHASES + 1);
        $display("seen %0d repeated STARTs and %0d STOP requests.", book.restarts, book.stops);
        if (book.errors == 0 && book.pending_steps.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/i2cms_pkg.sv
rtl/i2cms_step.sv
rtl/i2cms_out_fifo.sv
rtl/i2c_master_transfer_sequencer.sv
dv/tb.sv
